[rtl/ncpf_pkg.sv]
// ----------------------------------------------------------------------------
// ncpf_pkg
// Shared types and constants for the nearest corner pixel finder.
// ----------------------------------------------------------------------------
package ncpf_pkg;

  localparam int MaxDim     = 1024;
  localparam int CoordW     = $clog2(MaxDim);
  localparam int DimW       = CoordW + 1;
  localparam int DistW      = 2 * CoordW + 2;
  localparam int CfgW       = 11;
  localparam int PixW       = 8;
  localparam int ThrW       = 8;
  localparam int NumCorners = 4;
  localparam int OutDataW   = ((2 * NumCorners * CoordW + 7) / 8) * 8;
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  localparam logic [CfgW-1:0] WidthReset     = CfgW'(640);
  localparam logic [CfgW-1:0] HeightReset    = CfgW'(480);
  localparam logic [ThrW-1:0] ThresholdReset = ThrW'(128);

  typedef enum logic [1:0] {
    RegWidth     = 2'd0,
    RegHeight    = 2'd1,
    RegThreshold = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CfgW-1:0] width;
    logic [CfgW-1:0] height;
    logic [ThrW-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              fg;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } point_t;

endpackage

[rtl/nearest_corner_pixel_finder.sv]
// ----------------------------------------------------------------------------
// nearest_corner_pixel_finder
// Finds the foreground pixels nearest to the four frame corners.
// ----------------------------------------------------------------------------
// Takes one 8-bit pixel per beat in raster order; column and row are counted
// internally from frame_width. Pixels at or above pixel_threshold are tested
// against (0,0), (W,0), (0,H), (W,H) by squared distance; each corner keeps
// the nearest, earliest on ties. The beat with in_tlast closes the frame and
// yields one result beat with the four points and a found flag (all points 0
// when found is 0). Sustained rate is one pixel per clock while no earlier
// result is waiting on out_tready; a pixel is stored in a 4-entry queue,
// its distances are registered as it leaves, and the trackers and the
// result register update from that registered stage. While an earlier
// result is still held the closing pixel waits in the back end, the queue
// fills and in_tready drops after four more pixels. Write configuration
// only while no frame is in flight.
module nearest_corner_pixel_finder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ncpf_pkg::PixW-1:0]            in_tdata,   // pixel
  input  logic                                 in_tlast,   // frame_last
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // top_left_x, top_left_y, top_right_x, top_right_y,
  // bottom_left_x, bottom_left_y, bottom_right_x, bottom_right_y
  output logic [ncpf_pkg::OutDataW-1:0]        out_tdata,
  output logic                                 out_tuser,  // found
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [ncpf_pkg::CfgW-1:0]            cfg_wdata
);

  ncpf_pkg::cfg_t   cfg_r;
  ncpf_pkg::item_t  push_item;
  ncpf_pkg::item_t  q_head;
  logic             push;
  logic             q_ready;
  logic             q_valid;
  logic             pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width     <= ncpf_pkg::WidthReset;
      cfg_r.height    <= ncpf_pkg::HeightReset;
      cfg_r.threshold <= ncpf_pkg::ThresholdReset;
    end else if (cfg_we) begin
      unique case (ncpf_pkg::cfg_reg_t'(cfg_index))
        ncpf_pkg::RegWidth:     cfg_r.width     <= cfg_wdata;
        ncpf_pkg::RegHeight:    cfg_r.height    <= cfg_wdata;
        ncpf_pkg::RegThreshold: cfg_r.threshold <= cfg_wdata[ncpf_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = q_ready;

  ncpf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_pixel (in_tdata),
    .in_last  (in_tlast),
    .q_ready  (q_ready),
    .push     (push),
    .item     (push_item)
  );

  ncpf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .ready     (q_ready),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  ncpf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_found (out_tuser)
  );

endmodule

[rtl/ncpf_front.sv]
// ----------------------------------------------------------------------------
// ncpf_front
// Accepts pixels, tracks raster position and tags foreground pixels.
// ----------------------------------------------------------------------------
module ncpf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ncpf_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  input  logic [ncpf_pkg::PixW-1:0]     in_pixel,
  input  logic                          in_last,
  input  logic                          q_ready,
  output logic                          push,
  output ncpf_pkg::item_t               item
);

  logic [ncpf_pkg::CoordW-1:0] x_r, x_nxt;
  logic [ncpf_pkg::CoordW-1:0] y_r, y_nxt;
  logic [ncpf_pkg::DimW-1:0]   x_plus;
  logic [ncpf_pkg::DimW-1:0]   y_plus;
  logic                        row_wrap;

  assign push   = in_valid && q_ready;
  assign x_plus = {1'b0, x_r} + ncpf_pkg::DimW'(1);
  assign y_plus = {1'b0, y_r} + ncpf_pkg::DimW'(1);
  assign row_wrap = (32'(x_plus) >= 32'(cfg.width)) || (32'(x_plus) >= ncpf_pkg::MaxDim);

  assign item.x    = x_r;
  assign item.y    = y_r;
  assign item.fg   = (in_pixel >= cfg.threshold);
  assign item.last = in_last;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (push) begin
      if (in_last) begin
        x_nxt = '0;
        y_nxt = '0;
      end else if (row_wrap) begin
        x_nxt = '0;
        y_nxt = (32'(y_plus) >= ncpf_pkg::MaxDim) ? '0 : y_plus[ncpf_pkg::CoordW-1:0];
      end else begin
        x_nxt = x_plus[ncpf_pkg::CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

endmodule

[rtl/ncpf_queue.sv]
// ----------------------------------------------------------------------------
// ncpf_queue
// Short FIFO between the pixel front end and the tracker back end.
// ----------------------------------------------------------------------------
module ncpf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ncpf_pkg::item_t push_item,
  output logic            ready,
  input  logic            pop,
  output logic            valid,
  output ncpf_pkg::item_t head
);

  ncpf_pkg::item_t                mem_r [ncpf_pkg::QueueDepth];
  logic [ncpf_pkg::QueueAw-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [ncpf_pkg::QueueAw-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [ncpf_pkg::QueueAw:0]     count_r, count_nxt;

  assign ready = (32'(count_r) < ncpf_pkg::QueueDepth);
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + ncpf_pkg::QueueAw'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + ncpf_pkg::QueueAw'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (ncpf_pkg::QueueAw+1)'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - (ncpf_pkg::QueueAw+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/ncpf_back.sv]
// ----------------------------------------------------------------------------
// ncpf_back
// Squared distances to the four corners, per-corner best tracking and the
// result register.
// ----------------------------------------------------------------------------
module ncpf_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ncpf_pkg::cfg_t                  cfg,
  input  logic                            q_valid,
  input  ncpf_pkg::item_t                 q_head,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ncpf_pkg::OutDataW-1:0]   out_data,
  output logic                            out_found
);

  localparam int Nc = ncpf_pkg::NumCorners;
  localparam int Cw = ncpf_pkg::CoordW;

  logic [ncpf_pkg::DimW-1:0]    cw, ch;
  logic [ncpf_pkg::DimW-1:0]    hx, hy;
  logic [ncpf_pkg::DimW-1:0]    dx [Nc];
  logic [ncpf_pkg::DimW-1:0]    dy [Nc];
  logic [2*ncpf_pkg::DimW-1:0]  sqx [Nc];
  logic [2*ncpf_pkg::DimW-1:0]  sqy [Nc];
  logic [2*ncpf_pkg::DimW:0]    dsum [Nc];

  logic                         s1_valid_r, s1_valid_nxt;
  ncpf_pkg::item_t              s1_item_r;
  logic [ncpf_pkg::DistW-1:0]   s1_dist_r [Nc];

  logic [ncpf_pkg::DistW-1:0]   best_dist_r [Nc];
  logic [ncpf_pkg::DistW-1:0]   best_dist_nxt [Nc];
  ncpf_pkg::point_t             best_pt_r [Nc];
  ncpf_pkg::point_t             best_pt_nxt [Nc];
  logic                         any_seen_r, any_seen_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [ncpf_pkg::OutDataW-1:0] out_data_r;
  logic                         out_found_r;

  logic                         take;
  logic                         upd;
  logic [ncpf_pkg::OutDataW-1:0] res_data;

  assign cw = (32'(cfg.width) > ncpf_pkg::MaxDim) ? ncpf_pkg::DimW'(ncpf_pkg::MaxDim)
                                                  : ncpf_pkg::DimW'(cfg.width);
  assign ch = (32'(cfg.height) > ncpf_pkg::MaxDim) ? ncpf_pkg::DimW'(ncpf_pkg::MaxDim)
                                                   : ncpf_pkg::DimW'(cfg.height);
  assign hx = {1'b0, q_head.x};
  assign hy = {1'b0, q_head.y};

  // corner k: bit 0 selects right edge, bit 1 selects bottom edge
  always_comb begin
    for (int k = 0; k < Nc; k++) begin
      if (k % 2 == 1) begin
        dx[k] = (hx > cw) ? hx - cw : cw - hx;
      end else begin
        dx[k] = hx;
      end
      if (k / 2 == 1) begin
        dy[k] = (hy > ch) ? hy - ch : ch - hy;
      end else begin
        dy[k] = hy;
      end
      sqx[k]  = (2*ncpf_pkg::DimW)'(dx[k]) * (2*ncpf_pkg::DimW)'(dx[k]);
      sqy[k]  = (2*ncpf_pkg::DimW)'(dy[k]) * (2*ncpf_pkg::DimW)'(dy[k]);
      dsum[k] = {1'b0, sqx[k]} + {1'b0, sqy[k]};
    end
  end

  assign take = !s1_item_r.last || !out_valid_r || out_ready;
  assign upd  = s1_valid_r && take;
  assign pop  = q_valid && (!s1_valid_r || take);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (pop) begin
      s1_valid_nxt = 1'b1;
    end else if (upd) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    any_seen_nxt = any_seen_r || s1_item_r.fg;
    for (int k = 0; k < Nc; k++) begin
      best_dist_nxt[k] = best_dist_r[k];
      best_pt_nxt[k]   = best_pt_r[k];
      if (s1_item_r.fg && (!any_seen_r || s1_dist_r[k] < best_dist_r[k])) begin
        best_dist_nxt[k] = s1_dist_r[k];
        best_pt_nxt[k].x = s1_item_r.x;
        best_pt_nxt[k].y = s1_item_r.y;
      end
    end
  end

  always_comb begin
    res_data = '0;
    for (int k = 0; k < Nc; k++) begin
      res_data[2*k*Cw +: Cw]     = best_pt_nxt[k].x;
      res_data[(2*k+1)*Cw +: Cw] = best_pt_nxt[k].y;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (upd && s1_item_r.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item_r <= q_head;
      for (int k = 0; k < Nc; k++) begin
        s1_dist_r[k] <= dsum[k][ncpf_pkg::DistW-1:0];
      end
    end
    if (upd && s1_item_r.last) begin
      out_data_r  <= res_data;
      out_found_r <= any_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      any_seen_r  <= 1'b0;
      for (int k = 0; k < Nc; k++) begin
        best_dist_r[k] <= '1;
        best_pt_r[k]   <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (upd) begin
        if (s1_item_r.last) begin
          any_seen_r <= 1'b0;
          for (int k = 0; k < Nc; k++) begin
            best_dist_r[k] <= '1;
            best_pt_r[k]   <= '0;
          end
        end else begin
          any_seen_r <= any_seen_nxt;
          for (int k = 0; k < Nc; k++) begin
            best_dist_r[k] <= best_dist_nxt[k];
            best_pt_r[k]   <= best_pt_nxt[k];
          end
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_found = out_found_r;

endmodule
